// ----- hw/rtl/atb_pkg.sv -----
// ----------------------------------------------------------------------------
// atb_pkg
// shared types and constants for the alias table builder
// ----------------------------------------------------------------------------
package atb_pkg;

    localparam int VALUE_W           = 23;
    localparam int OUT_IDX_W         = 6;
    localparam int DEF_MAX_ENTRIES   = 64;
    localparam int DEF_FRACTION_BITS = 16;

    typedef struct packed {
        logic [VALUE_W-1:0] prob_value;
        logic               last_entry;
    } item_t;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] entry_index;
        logic [VALUE_W-1:0]   threshold;
        logic [OUT_IDX_W-1:0] alias_index;
        logic                 last_result;
    } result_t;

    // stack control
    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } stack_ctl_t;

    // alias store control
    typedef struct packed {
        logic clear;
        logic we;
    } alias_ctl_t;

endpackage

// ----- hw/rtl/atb_value_mem.sv -----
// ----------------------------------------------------------------------------
// atb_value_mem
// probability value store, one write port and two registered read ports
// ----------------------------------------------------------------------------
module atb_value_mem #(
    parameter int DEPTH = atb_pkg::DEF_MAX_ENTRIES,
    parameter int IDX_W = $clog2(atb_pkg::DEF_MAX_ENTRIES)
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [IDX_W-1:0]           waddr,
    input  logic [atb_pkg::VALUE_W-1:0] wdata,
    input  logic [IDX_W-1:0]           addr_a,
    input  logic [IDX_W-1:0]           addr_b,
    output logic [atb_pkg::VALUE_W-1:0] rd_a,
    output logic [atb_pkg::VALUE_W-1:0] rd_b
);
    import atb_pkg::*;

    logic [VALUE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_a <= mem[addr_a];
        rd_b <= mem[addr_b];
    end

endmodule

// ----- hw/rtl/atb_stack.sv -----
// ----------------------------------------------------------------------------
// atb_stack
// index stack in a synchronous memory, pop data registered
// ----------------------------------------------------------------------------
module atb_stack #(
    parameter int DEPTH = atb_pkg::DEF_MAX_ENTRIES,
    parameter int IDX_W = $clog2(atb_pkg::DEF_MAX_ENTRIES),
    parameter int CNT_W = $clog2(atb_pkg::DEF_MAX_ENTRIES + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  atb_pkg::stack_ctl_t ctl,
    input  logic [IDX_W-1:0]    push_data,
    output logic [IDX_W-1:0]    pop_data,
    output logic [CNT_W-1:0]    count
);
    import atb_pkg::*;

    logic [IDX_W-1:0] mem [DEPTH];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] count_dec;

    assign count_dec = count_reg - CNT_W'(1);
    assign count     = count_reg;

    always_comb
    begin
        priority if (ctl.clear)
        begin
            count_next = '0;
        end
        else if (ctl.push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctl.pop)
        begin
            count_next = count_dec;
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push && !ctl.clear)
        begin
            mem[count_reg[IDX_W-1:0]] <= push_data;
        end
        if (ctl.pop)
        begin
            pop_data <= mem[count_dec[IDX_W-1:0]];
        end
    end

endmodule

// ----- hw/rtl/atb_alias_mem.sv -----
// ----------------------------------------------------------------------------
// atb_alias_mem
// alias partner store, unwritten entries read as zero through valid bits
// ----------------------------------------------------------------------------
module atb_alias_mem #(
    parameter int DEPTH = atb_pkg::DEF_MAX_ENTRIES,
    parameter int IDX_W = $clog2(atb_pkg::DEF_MAX_ENTRIES)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  atb_pkg::alias_ctl_t ctl,
    input  logic [IDX_W-1:0]    waddr,
    input  logic [IDX_W-1:0]    wdata,
    input  logic [IDX_W-1:0]    raddr,
    output logic [IDX_W-1:0]    rd
);
    import atb_pkg::*;

    logic [IDX_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;
    logic [IDX_W-1:0] mem_q;
    logic             valid_q;

    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.clear)
        begin
            valid_next = '0;
        end
        else if (ctl.we)
        begin
            valid_next[waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            valid_q   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            valid_q   <= valid_reg[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[waddr] <= wdata;
        end
        mem_q <= mem[raddr];
    end

    assign rd = valid_q ? mem_q : '0;

endmodule

// ----- hw/rtl/alias_table_builder_unit.sv -----
// ----------------------------------------------------------------------------
// alias_table_builder_unit
// builds an alias sampling table from scaled probabilities loaded in order
// ----------------------------------------------------------------------------
// Loading takes one probability per cycle with busy low. The entry flagged
// last, or the one that fills the table, starts the build and raises busy.
// Pairing then takes each small/large pair through stack pop, value store
// read and value and alias write-back, in that order since the stack and
// value memories have registered reads, and the stack pop step ends it
// when a stack runs dry. Emission follows: one entry per cycle in index
// order, each shown for one cycle with result_strobe; the receiver cannot
// stall, so every strobe must be taken. Busy stays high through emission,
// and the last result appears in the cycle after busy falls, where a new
// set may already start loading.
module alias_table_builder_unit #(
    parameter int MAX_ENTRIES   = atb_pkg::DEF_MAX_ENTRIES,
    parameter int FRACTION_BITS = atb_pkg::DEF_FRACTION_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  atb_pkg::item_t   item,
    output logic             result_strobe,
    output atb_pkg::result_t result
);
    import atb_pkg::*;

    localparam int IDX_W  = $clog2(MAX_ENTRIES);
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int WIDE_W = ((FRACTION_BITS + 1 > VALUE_W) ? FRACTION_BITS + 1 : VALUE_W) + 1;
    localparam logic [WIDE_W-1:0] ONE_WIDE = WIDE_W'(1) << FRACTION_BITS;
    localparam logic [IDX_W-1:0]  LAST_POS = IDX_W'(MAX_ENTRIES - 1);

    typedef enum logic [4:0] {
        S_LOAD = 5'b00001,
        S_POP  = 5'b00010,
        S_READ = 5'b00100,
        S_UPD  = 5'b01000,
        S_EMIT = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] load_cnt_reg, load_cnt_next;
    logic [IDX_W-1:0] last_idx_reg, last_idx_next;
    logic [IDX_W-1:0] emit_cnt_reg, emit_cnt_next;
    logic [IDX_W-1:0] emit_idx_reg, emit_idx_next;
    logic             emit_last_reg, emit_last_next;
    logic             pend_reg, pend_next;

    stack_ctl_t       small_ctl, large_ctl;
    logic [IDX_W-1:0] push_data;
    logic [IDX_W-1:0] small_top_idx, large_top_idx;
    logic [CNT_W-1:0] small_cnt, large_cnt;

    logic               vm_we;
    logic [IDX_W-1:0]   vm_waddr;
    logic [VALUE_W-1:0] vm_wdata;
    logic [IDX_W-1:0]   vm_addr_a, vm_addr_b;
    logic [VALUE_W-1:0] vm_rd_a, vm_rd_b;

    alias_ctl_t       al_ctl;
    logic [IDX_W-1:0] al_rd;

    logic               accept;
    logic               is_last;
    logic               in_below;
    logic [WIDE_W-1:0]  pair_sum;
    logic [VALUE_W-1:0] pair_val;
    logic               pair_below;

    assign busy     = (state_reg != S_LOAD);
    assign accept   = start && !busy;
    assign is_last  = item.last_entry || (load_cnt_reg == LAST_POS);
    assign in_below = (WIDE_W'(item.prob_value) < ONE_WIDE);

    // port a holds the large entry, port b the small one
    assign pair_sum   = WIDE_W'(vm_rd_a) + WIDE_W'(vm_rd_b) - ONE_WIDE;
    assign pair_val   = pair_sum[VALUE_W-1:0];
    assign pair_below = (WIDE_W'(pair_val) < ONE_WIDE);

    always_comb
    begin
        state_next     = state_reg;
        load_cnt_next  = load_cnt_reg;
        last_idx_next  = last_idx_reg;
        emit_cnt_next  = emit_cnt_reg;
        emit_idx_next  = emit_idx_reg;
        emit_last_next = emit_last_reg;
        pend_next      = 1'b0;
        small_ctl      = '0;
        large_ctl      = '0;
        push_data      = load_cnt_reg;
        vm_we          = 1'b0;
        vm_waddr       = load_cnt_reg;
        vm_wdata       = item.prob_value;
        vm_addr_a      = emit_cnt_reg;
        vm_addr_b      = small_top_idx;
        al_ctl         = '0;

        unique case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    vm_we          = 1'b1;
                    small_ctl.push = in_below;
                    large_ctl.push = !in_below;
                    al_ctl.clear   = (load_cnt_reg == '0);
                    if (is_last)
                    begin
                        load_cnt_next = '0;
                        last_idx_next = load_cnt_reg;
                        state_next    = S_POP;
                    end
                    else
                    begin
                        load_cnt_next = load_cnt_reg + IDX_W'(1);
                    end
                end
            end
            S_POP:
            begin
                if (small_cnt == '0 || large_cnt == '0)
                begin
                    small_ctl.clear = 1'b1;
                    large_ctl.clear = 1'b1;
                    emit_cnt_next   = '0;
                    state_next      = S_EMIT;
                end
                else
                begin
                    small_ctl.pop = 1'b1;
                    large_ctl.pop = 1'b1;
                    state_next    = S_READ;
                end
            end
            S_READ:
            begin
                vm_addr_a  = large_top_idx;
                vm_addr_b  = small_top_idx;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                vm_we          = 1'b1;
                vm_waddr       = large_top_idx;
                vm_wdata       = pair_val;
                al_ctl.we      = 1'b1;
                push_data      = large_top_idx;
                small_ctl.push = pair_below;
                large_ctl.push = !pair_below;
                state_next     = S_POP;
            end
            S_EMIT:
            begin
                pend_next      = 1'b1;
                emit_idx_next  = emit_cnt_reg;
                emit_last_next = (emit_cnt_reg == last_idx_reg);
                if (emit_cnt_reg == last_idx_reg)
                begin
                    state_next = S_LOAD;
                end
                else
                begin
                    emit_cnt_next = emit_cnt_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_LOAD;
            load_cnt_reg <= '0;
            pend_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            pend_reg     <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_idx_reg  <= last_idx_next;
        emit_cnt_reg  <= emit_cnt_next;
        emit_idx_reg  <= emit_idx_next;
        emit_last_reg <= emit_last_next;
    end

    atb_stack #(
        .DEPTH (MAX_ENTRIES),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_small_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (small_ctl),
        .push_data (push_data),
        .pop_data  (small_top_idx),
        .count     (small_cnt)
    );

    atb_stack #(
        .DEPTH (MAX_ENTRIES),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_large_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (large_ctl),
        .push_data (push_data),
        .pop_data  (large_top_idx),
        .count     (large_cnt)
    );

    atb_value_mem #(
        .DEPTH (MAX_ENTRIES),
        .IDX_W (IDX_W)
    ) u_value_mem (
        .clk    (clk),
        .we     (vm_we),
        .waddr  (vm_waddr),
        .wdata  (vm_wdata),
        .addr_a (vm_addr_a),
        .addr_b (vm_addr_b),
        .rd_a   (vm_rd_a),
        .rd_b   (vm_rd_b)
    );

    atb_alias_mem #(
        .DEPTH (MAX_ENTRIES),
        .IDX_W (IDX_W)
    ) u_alias_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (al_ctl),
        .waddr (small_top_idx),
        .wdata (large_top_idx),
        .raddr (emit_cnt_reg),
        .rd    (al_rd)
    );

    assign result_strobe      = pend_reg;
    assign result.entry_index = OUT_IDX_W'(emit_idx_reg);
    assign result.threshold   = vm_rd_a;
    assign result.alias_index = OUT_IDX_W'(al_rd);
    assign result.last_result = emit_last_reg;

endmodule

// ----- hw/rtl/atb_checker.sv -----
// ----------------------------------------------------------------------------
// atb_checker
// port-level checks of the alias table builder, bound to the top level
// ----------------------------------------------------------------------------
module atb_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input atb_pkg::item_t   item,
    input logic             result_strobe,
    input atb_pkg::result_t result
);
    import atb_pkg::*;

    // a transaction flagged last starts the build
    a_last_starts_build: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.last_entry) |=> busy)
        else $error("build did not start after last entry");

    // emission runs in index order without gaps
    a_emit_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !result.last_result) |=>
        (result_strobe && result.entry_index == $past(result.entry_index) + OUT_IDX_W'(1)))
        else $error("emitted entries not contiguous");

    // emission stops after the marked entry
    a_last_ends_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result.last_result) |=> !result_strobe)
        else $error("result after the last entry");

    // each table starts at entry zero
    a_emit_from_zero: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_strobe) |-> (result.entry_index == '0))
        else $error("emission did not start at entry zero");

    // results only while building or in the cycle after it ends
    a_strobe_in_build: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(busy))
        else $error("result outside a build");

endmodule

bind alias_table_builder_unit atb_checker u_atb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .item          (item),
    .result_strobe (result_strobe),
    .result        (result)
);

// ----- test/tb_alias_table_builder_unit.sv -----
// ----------------------------------------------------------------------------
// tb_alias_table_builder_unit
// self-checking bench for the alias table builder: probability sets are
// loaded through the start/busy handshake, each finished table is predicted
// in the bench, and every strobed entry is compared in order against it
// ----------------------------------------------------------------------------
module tb_alias_table_builder_unit;
    import atb_pkg::*;

    localparam int          TABLE_DEPTH  = DEF_MAX_ENTRIES;
    localparam int unsigned ONE_Q        = 1 << DEF_FRACTION_BITS;
    localparam int unsigned PROB_MAX     = 4194304;
    localparam int          PHASE_ITEMS  = 120;
    localparam int          TAIL_CYCLES  = 16;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          REPORT_LIMIT = 10;

    logic    clk           = 1'b0;
    logic    rst_n         = 1'b0;
    logic    start         = 1'b0;
    item_t   item          = '0;
    logic    busy;
    logic    result_strobe;
    result_t result;

    alias_table_builder_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .item          (item),
        .result_strobe (result_strobe),
        .result        (result)
    );

    always #5 clk = ~clk;

    // table predictor state
    logic [VALUE_W-1:0]   thr_mem   [TABLE_DEPTH];
    logic [OUT_IDX_W-1:0] alias_mem [TABLE_DEPTH];
    logic [OUT_IDX_W-1:0] small_idx [TABLE_DEPTH];
    logic [OUT_IDX_W-1:0] large_idx [TABLE_DEPTH];
    int small_cnt = 0;
    int large_cnt = 0;
    int fill_cnt  = 0;

    item_t   pending_items[$];
    result_t expected_entries[$];

    int items_queued    = 0;
    int items_accepted  = 0;
    int tables_built    = 0;
    int pairs_made      = 0;
    int entries_checked = 0;
    int error_cnt       = 0;
    int cycle_cnt       = 0;
    int idle_pct        = 0;

    function automatic void file_by_value(input int idx);
        if (thr_mem[idx] < ONE_Q) begin
            small_idx[small_cnt] = OUT_IDX_W'(idx);
            small_cnt++;
        end
        else begin
            large_idx[large_cnt] = OUT_IDX_W'(idx);
            large_cnt++;
        end
    endfunction

    function automatic void predict_table(input item_t it);
        int          pos;
        int          s;
        int          l;
        logic [31:0] merged;
        result_t     r;
        if (fill_cnt == 0) begin
            foreach (alias_mem[k])
                alias_mem[k] = '0;
            small_cnt = 0;
            large_cnt = 0;
        end
        pos = fill_cnt;
        thr_mem[pos] = it.prob_value;
        file_by_value(pos);
        fill_cnt = pos + 1;
        // a full table builds even without the last flag
        if (!it.last_entry && fill_cnt < TABLE_DEPTH)
            return;
        while (small_cnt != 0 && large_cnt != 0) begin
            small_cnt--;
            s = small_idx[small_cnt];
            large_cnt--;
            l = large_idx[large_cnt];
            alias_mem[s] = OUT_IDX_W'(l);
            merged = 32'(thr_mem[l]) + 32'(thr_mem[s]) - ONE_Q;
            thr_mem[l] = merged[VALUE_W-1:0];
            file_by_value(l);
            pairs_made++;
        end
        for (int k = 0; k < fill_cnt; k++) begin
            r.entry_index = OUT_IDX_W'(k);
            r.threshold   = thr_mem[k];
            r.alias_index = alias_mem[k];
            r.last_result = (k == fill_cnt - 1);
            expected_entries.insert(expected_entries.size(), r);
        end
        tables_built++;
        fill_cnt  = 0;
        small_cnt = 0;
        large_cnt = 0;
    endfunction

    function automatic void log_error(input string msg);
        error_cnt++;
        if (error_cnt <= REPORT_LIMIT)
            $display("[%0d] error: %s", cycle_cnt, msg);
    endfunction

    task automatic push_entry(input int unsigned value, input bit last);
        item_t it;
        it.prob_value = VALUE_W'(value);
        it.last_entry = last;
        pending_items.insert(pending_items.size(), it);
        items_queued++;
    endtask

    // shaped sets have mean one, noise sets take any value in range
    task automatic queue_table(input int n, input bit shaped, input bit end_flag);
        int unsigned     weights [TABLE_DEPTH];
        longint unsigned total;
        longint unsigned v;
        total = 0;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(9))
                0:       weights[k] = 0;
                1:       weights[k] = $urandom_range(20000);
                default: weights[k] = $urandom_range(1000);
            endcase
            total += weights[k];
        end
        for (int k = 0; k < n; k++) begin
            if (!shaped)
                v = $urandom_range(1) ? $urandom_range(PROB_MAX) : $urandom_range(2 * ONE_Q);
            else if (total == 0)
                v = ONE_Q;
            else
                v = (longint'(weights[k]) * n * ONE_Q) / total;
            if (v > PROB_MAX)
                v = PROB_MAX;
            push_entry(int'(v), (k == n - 1) ? end_flag : 1'b0);
        end
    endtask

    task automatic wait_drained();
        while (items_accepted != items_queued || expected_entries.size() != 0)
            @(posedge clk);
    endtask

    // driver: one transaction per edge with start high and busy low
    always @(posedge clk) begin
        if (!rst_n) begin
            start <= 1'b0;
        end
        else begin
            if (start && !busy) begin
                predict_table(item);
                items_accepted++;
            end
            if (!(start && busy)) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    item  <= pending_items.pop_front();
                    start <= 1'b1;
                end
                else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: every strobed entry is checked against the oldest prediction
    always @(posedge clk) begin
        result_t want;
        if (rst_n && result_strobe) begin
            entries_checked++;
            if (expected_entries.size() == 0) begin
                log_error($sformatf("unexpected entry index %0d thr %0h alias %0d last %0b",
                          result.entry_index, result.threshold, result.alias_index,
                          result.last_result));
            end
            else begin
                want = expected_entries.pop_front();
                if (result.entry_index !== want.entry_index
                    || result.threshold !== want.threshold
                    || result.alias_index !== want.alias_index
                    || result.last_result !== want.last_result)
                    log_error($sformatf({"entry mismatch: exp index %0d thr %0h alias %0d ",
                              "last %0b, got index %0d thr %0h alias %0d last %0b"},
                              want.entry_index, want.threshold, want.alias_index,
                              want.last_result, result.entry_index, result.threshold,
                              result.alias_index, result.last_result));
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d entries still expected",
                     cycle_cnt, expected_entries.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int target;
        int n;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed sets: extremes, pairing, all large, all small, bit patterns
        push_entry(0, 1'b1);
        push_entry(PROB_MAX, 1'b1);
        push_entry(0, 1'b0);
        push_entry(2 * ONE_Q, 1'b1);
        push_entry(ONE_Q - 1, 1'b0);
        push_entry(ONE_Q, 1'b0);
        push_entry(ONE_Q + 1, 1'b1);
        push_entry(ONE_Q, 1'b0);
        push_entry(ONE_Q, 1'b0);
        push_entry(ONE_Q, 1'b1);
        push_entry(1, 1'b0);
        push_entry(2, 1'b0);
        push_entry(3, 1'b1);
        push_entry(PROB_MAX, 1'b0);
        push_entry(32'h2AAAAA, 1'b0);
        push_entry(32'h155555, 1'b0);
        push_entry(0, 1'b1);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                1:       idle_pct = 82;
                3:       idle_pct = 34;
                default: idle_pct = 0;
            endcase
            target = items_queued + PHASE_ITEMS;
            // full tables: one built by overflow, one flagged on its final entry
            if (ph == 0)
                queue_table(TABLE_DEPTH, 1'b1, 1'b0);
            if (ph == 2)
                queue_table(TABLE_DEPTH, 1'b0, 1'b1);
            while (items_queued < target) begin
                n = ($urandom_range(19) == 0) ? $urandom_range(33, TABLE_DEPTH)
                                              : $urandom_range(1, 12);
                queue_table(n, $urandom_range(4) != 0,
                            (n == TABLE_DEPTH) ? 1'($urandom_range(1)) : 1'b1);
            end
            // sender holds off until the whole phase has come back
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("%0d probability entries loaded into %0d tables, %0d pairings, %0d %s",
                 items_accepted, tables_built, pairs_made, entries_checked,
                 "entries compared");
        $display("%s %s", "sender idle levels of 0, 82 and 34 percent,",
                 "full tables with and without a last flag");
        if (error_cnt == 0 && expected_entries.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end
        else begin
            $display("%0d errors, %0d entries never seen", error_cnt, expected_entries.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
